>>> sv/smhd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smhd_pkg
// shared types and constants of the sliding minimum hamming distance block
// ----------------------------------------------------------------------------
package smhd_pkg;

    localparam int MAX_LEN  = 64;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int SYM_W    = 3;
    localparam int ACT_W    = 2;
    localparam int DIST_W   = 7;
    localparam int DIST_MAX = (1 << DIST_W) - 1;

    localparam logic [ACT_W-1:0] ACT_FIRST   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SECOND  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [SYM_W-1:0] symbol;
    } t_in_word;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_out_word;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [CNT_W-1:0] v);
        if (int'(v) > DIST_MAX) begin
            return DIST_W'(DIST_MAX);
        end
        return DIST_W'(v);
    endfunction

endpackage
`default_nettype wire

>>> sv/smhd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smhd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module smhd_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> sv/sliding_min_hamming_distance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_min_hamming_distance
// minimum mismatch count of the shorter of two symbol sequences over all
// alignments along the longer one
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall / i_in_word. an append word writes
// one symbol into the first or second store; append words are
// taken back to back. symbols beyond 64 per store are dropped and flagged.
// a compute word starts a walk over all offsets of the shorter sequence:
// one symbol pair is read from the two rams per cycle, and the result is
// registered after the final compare, or directly on the compute word
// when the shorter sequence is empty. the input is stalled during the
// walk; both lengths and the drop flag clear on compute.
// output channel: o_out_valid / i_out_stall / o_out_word, one result word
// per compute, held in an output register. appends are taken while the
// result waits; a further compute stalls until the result is taken.
// reset clears lengths, flag and handshake state; ram contents stay.
// ----------------------------------------------------------------------------
module sliding_min_hamming_distance
    import smhd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_word  o_out_word
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_cnt1, r_cnt2;
    logic             r_drop;
    logic             r_swap;
    logic [CNT_W-1:0] r_short;
    logic [ADDR_W-1:0] r_diff;
    logic [ADDR_W-1:0] r_off, r_j;
    logic             r_cmp_v, r_cmp_last, r_cmp_final;
    logic [CNT_W-1:0] r_miss, r_best;
    logic             r_ovf;
    logic             r_out_v;
    t_out_word        r_out_word;

    logic             in_acc;
    logic             is_app1, is_app2, is_comp;
    logic [CNT_W-1:0] n_short, n_long;
    logic             n_swap;
    logic             j_last, off_last;
    logic [ADDR_W-1:0] addr_s, addr_l;
    logic [ADDR_W-1:0] ram1_raddr, ram2_raddr;
    logic [SYM_W-1:0] rd1, rd2;
    logic [CNT_W-1:0] sum;
    logic [CNT_W-1:0] n_min;
    logic             we1, we2;

    assign is_app1 = i_in_word.action == ACT_FIRST;
    assign is_app2 = i_in_word.action == ACT_SECOND;
    assign is_comp = i_in_word.action == ACT_COMPUTE;

    assign o_in_stall = (r_state != ST_IDLE) || (r_out_v && is_comp);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign we1 = in_acc && is_app1 && (int'(r_cnt1) < MAX_LEN);
    assign we2 = in_acc && is_app2 && (int'(r_cnt2) < MAX_LEN);

    assign n_swap  = r_cnt1 > r_cnt2;
    assign n_short = n_swap ? r_cnt2 : r_cnt1;
    assign n_long  = n_swap ? r_cnt1 : r_cnt2;

    assign j_last   = {1'b0, r_j} == (r_short - CNT_W'(1));
    assign off_last = r_off == r_diff;
    assign addr_s   = r_j;
    assign addr_l   = r_off + r_j;

    assign ram1_raddr = r_swap ? addr_l : addr_s;
    assign ram2_raddr = r_swap ? addr_s : addr_l;

    assign sum   = r_miss + CNT_W'(rd1 != rd2);
    assign n_min = (sum < r_best) ? sum : r_best;

    smhd_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_cnt1[ADDR_W-1:0]),
        .i_wdata (i_in_word.symbol),
        .i_raddr (ram1_raddr),
        .o_rdata (rd1)
    );

    smhd_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_ram2 (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (r_cnt2[ADDR_W-1:0]),
        .i_wdata (i_in_word.symbol),
        .i_raddr (ram2_raddr),
        .o_rdata (rd2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt1  <= '0;
            r_cnt2  <= '0;
            r_drop  <= 1'b0;
            r_cmp_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_cmp_v <= 1'b0;
            if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end

            // load and compute start
            if (in_acc) begin
                if (is_app1) begin
                    if (we1) begin
                        r_cnt1 <= r_cnt1 + CNT_W'(1);
                    end else begin
                        r_drop <= 1'b1;
                    end
                end else if (is_app2) begin
                    if (we2) begin
                        r_cnt2 <= r_cnt2 + CNT_W'(1);
                    end else begin
                        r_drop <= 1'b1;
                    end
                end else if (is_comp) begin
                    r_cnt1 <= '0;
                    r_cnt2 <= '0;
                    r_drop <= 1'b0;
                    if (n_short == '0) begin
                        r_out_v             <= 1'b1;
                        r_out_word.distance <= '0;
                        r_out_word.overflow <= r_drop;
                    end else begin
                        r_state <= ST_RUN;
                    end
                end
            end

            // address walk over offsets and positions
            if (r_state == ST_RUN) begin
                r_cmp_v <= 1'b1;
                if (j_last && off_last) begin
                    r_state <= ST_WAIT;
                end
            end

            // final compare closes the walk
            if (r_cmp_v && r_cmp_final) begin
                r_out_v             <= 1'b1;
                r_out_word.distance <= sat_dist(n_min);
                r_out_word.overflow <= r_ovf;
                r_state             <= ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_comp) begin
            r_swap  <= n_swap;
            r_short <= n_short;
            r_diff  <= ADDR_W'(n_long - n_short);
            r_off   <= '0;
            r_j     <= '0;
            r_miss  <= '0;
            r_best  <= n_short;
            r_ovf   <= r_drop;
        end else begin
            if (r_state == ST_RUN) begin
                if (j_last) begin
                    r_j <= '0;
                    if (!off_last) begin
                        r_off <= r_off + ADDR_W'(1);
                    end
                end else begin
                    r_j <= r_j + ADDR_W'(1);
                end
            end
            if (r_cmp_v) begin
                if (r_cmp_last) begin
                    r_miss <= '0;
                    r_best <= n_min;
                end else begin
                    r_miss <= sum;
                end
            end
        end
        r_cmp_last  <= j_last;
        r_cmp_final <= j_last && off_last;
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

>>> sv/smhd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smhd_checker
// port level checks of the sliding minimum hamming distance block
// ----------------------------------------------------------------------------
module smhd_checker
    import smhd_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_stall,
    input t_in_word  i_in_word,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input t_out_word o_out_word
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("stalled result word changed");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(o_in_stall || (i_in_valid && i_in_word.action == ACT_COMPUTE)))
        else $error("result word without a compute");

    a_append_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_word.action != ACT_COMPUTE && !o_out_valid |=> !o_out_valid)
        else $error("result word after an append");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> int'(o_out_word.distance) <= MAX_LEN)
        else $error("distance above sequence depth");

endmodule

bind sliding_min_hamming_distance smhd_checker u_smhd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
`default_nettype wire

>>> test/sliding_min_hamming_distance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_min_hamming_distance_tb
// Self-checking bench for the sliding minimum hamming distance block. Symbol
// words are loaded into both sequences and followed by compute words. A
// behavioral predictor keeps its own copy of both sequences and computes each
// expected distance and overflow flag. Every result word is checked in order
// against that prediction, while both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module sliding_min_hamming_distance_tb;
    import smhd_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int GAP_MAX     = 19;
    localparam int HOLD_CYCLES = 400;
    localparam int WORD_TARGET = 1050;
    localparam int DRAIN_CYCLES = 1100;
    localparam int TIMEOUT_NS  = 2_000_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;

    // predictor state
    logic [SYM_W-1:0] first_seq [MAX_LEN];
    logic [SYM_W-1:0] second_seq [MAX_LEN];
    int               first_len = 0;
    int               second_len = 0;
    bit               symbol_dropped = 1'b0;
    t_out_word        pending_results [$];

    int mismatch_count = 0;
    int words_sent = 0;
    int hold_requests = 0;
    bit src_no_idle = 1'b0;

    sliding_min_hamming_distance i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int draw_gap(input bit no_idle);
        return no_idle ? 0 : int'($urandom_range(0, GAP_MAX));
    endfunction

    function automatic t_out_word min_sliding_distance();
        int        short_len;
        int        long_len;
        int        miss;
        int        best;
        bit        first_short;
        t_out_word r;
        first_short = (first_len <= second_len);
        short_len = first_short ? first_len : second_len;
        long_len = first_short ? second_len : first_len;
        best = short_len;
        for (int off = 0; off + short_len <= long_len; off++) begin
            miss = 0;
            for (int j = 0; j < short_len; j++) begin
                if (first_short ? (first_seq[j] != second_seq[off + j])
                                : (second_seq[j] != first_seq[off + j])) begin
                    miss++;
                end
            end
            if (miss < best) begin
                best = miss;
            end
        end
        if (best > DIST_MAX) begin
            best = DIST_MAX;
        end
        r.distance = DIST_W'(best);
        r.overflow = symbol_dropped;
        return r;
    endfunction

    task automatic predict_word(input t_in_word w);
        unique case (w.action)
            ACT_FIRST: begin
                if (first_len < MAX_LEN) begin
                    first_seq[first_len] = w.symbol;
                    first_len++;
                end else begin
                    symbol_dropped = 1'b1;
                end
            end
            ACT_SECOND: begin
                if (second_len < MAX_LEN) begin
                    second_seq[second_len] = w.symbol;
                    second_len++;
                end else begin
                    symbol_dropped = 1'b1;
                end
            end
            ACT_COMPUTE: begin
                pending_results.insert(pending_results.size(), min_sliding_distance());
                first_len = 0;
                second_len = 0;
                symbol_dropped = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_word(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym);
        t_in_word w;
        int       gap;
        w.action = act;
        w.symbol = sym;
        gap = draw_gap(src_no_idle);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_word(w);
        if (act != ACT_UNUSED) begin
            words_sent++;
        end
    endtask

    task automatic test_edge_cases();
        send_word(ACT_COMPUTE, 3'd0);
        send_word(ACT_FIRST, 3'd0);
        send_word(ACT_COMPUTE, 3'd7);
        send_word(ACT_SECOND, 3'd7);
        send_word(ACT_SECOND, 3'd5);
        send_word(ACT_SECOND, 3'd6);
        send_word(ACT_FIRST, 3'd6);
        send_word(ACT_UNUSED, 3'd7);
        send_word(ACT_COMPUTE, 3'd0);
        send_word(ACT_FIRST, 3'd4);
        send_word(ACT_UNUSED, 3'd0);
        send_word(ACT_SECOND, 3'd0);
        send_word(ACT_COMPUTE, 3'd2);
        // match only at the last offset
        send_word(ACT_FIRST, 3'd1);
        send_word(ACT_FIRST, 3'd2);
        send_word(ACT_SECOND, 3'd0);
        send_word(ACT_SECOND, 3'd0);
        send_word(ACT_SECOND, 3'd1);
        send_word(ACT_SECOND, 3'd2);
        send_word(ACT_COMPUTE, 3'd5);
        send_word(ACT_SECOND, 3'd3);
        send_word(ACT_SECOND, 3'd4);
        send_word(ACT_FIRST, 3'd4);
        send_word(ACT_FIRST, 3'd3);
        send_word(ACT_COMPUTE, 3'd1);
    endtask

    task automatic test_store_limits();
        logic [SYM_W-1:0] syms [MAX_LEN];
        src_no_idle = ($urandom_range(0, 1) == 0);
        // full stores differing everywhere
        for (int i = 0; i < MAX_LEN; i++) begin
            syms[i] = SYM_W'($urandom_range(0, 7));
            send_word(ACT_FIRST, syms[i]);
        end
        for (int i = 0; i < MAX_LEN; i++) begin
            send_word(ACT_SECOND, SYM_W'(syms[i] + SYM_W'($urandom_range(1, 7))));
        end
        send_word(ACT_COMPUTE, 3'd0);
        // overflow on the first sequence
        for (int i = 0; i < MAX_LEN + 2; i++) begin
            send_word(ACT_FIRST, SYM_W'($urandom_range(0, 7)));
        end
        send_word(ACT_SECOND, SYM_W'($urandom_range(0, 7)));
        send_word(ACT_COMPUTE, SYM_W'($urandom_range(0, 7)));
        // overflow on the second sequence, first empty
        for (int i = 0; i < MAX_LEN + 1; i++) begin
            send_word(ACT_SECOND, SYM_W'($urandom_range(0, 7)));
        end
        send_word(ACT_COMPUTE, 3'd0);
        src_no_idle = 1'b0;
    endtask

    task automatic test_result_backpressure();
        src_no_idle = 1'b1;
        hold_requests++;
        repeat (4) begin
            for (int n = 0; n < 3; n++) begin
                send_word(ACT_FIRST, SYM_W'($urandom_range(0, 4)));
            end
            for (int n = 0; n < 3; n++) begin
                send_word(ACT_SECOND, SYM_W'($urandom_range(0, 4)));
            end
            send_word(ACT_COMPUTE, 3'd0);
        end
        src_no_idle = 1'b0;
    endtask

    task automatic test_random_sequences();
        int pick;
        int len_first;
        int len_second;
        int sym_top;
        while (words_sent < WORD_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                len_first = $urandom_range(0, 10);
                len_second = $urandom_range(0, 10);
            end else if (pick < 95) begin
                len_first = $urandom_range(0, MAX_LEN);
                len_second = $urandom_range(0, MAX_LEN);
            end else begin
                len_first = $urandom_range(0, MAX_LEN + 4);
                len_second = $urandom_range(0, MAX_LEN + 4);
            end
            pick = $urandom_range(0, 2);
            sym_top = (pick == 0) ? 1 : ((pick == 1) ? 4 : 7);
            src_no_idle = ($urandom_range(0, 3) == 0);
            while (len_first > 0 || len_second > 0) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_word(ACT_UNUSED, SYM_W'($urandom_range(0, 7)));
                end
                if (len_second == 0 || (len_first > 0 && $urandom_range(0, 1) == 1)) begin
                    send_word(ACT_FIRST, SYM_W'($urandom_range(0, sym_top)));
                    len_first--;
                end else begin
                    send_word(ACT_SECOND, SYM_W'($urandom_range(0, sym_top)));
                    len_second--;
                end
            end
            send_word(ACT_COMPUTE, SYM_W'($urandom_range(0, 7)));
        end
        src_no_idle = 1'b0;
    endtask

    // result side: random stall per word, plus one long hold on request
    initial begin : result_sink
        int wait_left;
        int hold_seen;
        bit no_idle;
        wait_left = 0;
        hold_seen = 0;
        no_idle = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                wait_left = HOLD_CYCLES;
            end
            i_out_stall <= (wait_left > 0);
            if (wait_left > 0) begin
                wait_left--;
            end
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if ($urandom_range(0, 7) == 0) begin
                    no_idle = !no_idle;
                end
                wait_left = draw_gap(no_idle);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: distance %0d overflow %0d",
                       o_out_word.distance, o_out_word.overflow);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.distance !== want.distance) begin
                    $error("distance mismatch: expected %0d, actual %0d",
                           want.distance, o_out_word.distance);
                    mismatch_count++;
                end
                if (o_out_word.overflow !== want.overflow) begin
                    $error("overflow mismatch: expected %0d, actual %0d",
                           want.overflow, o_out_word.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial begin : run_tests
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_cases();
        test_store_limits();
        test_result_backpressure();
        test_random_sequences();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
